### rtl/rmt_pkg.sv
// Package: shared constants and types for the running median tracker.
`default_nettype none
package rmt_pkg;

	localparam int CAPACITY_DEF     = 1024;
	localparam int SAMPLE_WIDTH_DEF = 16;

	typedef struct packed {
		logic ins;
		logic seed;
		logic pull_rgt;
	} ctl_t;

endpackage
`default_nettype wire

### rtl/rmt_in_if.sv
// Interface: sample channel, valid/ready with one signed sample per item.
`default_nettype none
interface rmt_in_if #(
	parameter int SampleW = rmt_pkg::SAMPLE_WIDTH_DEF
);
	logic                      valid;
	logic                      ready;
	logic signed [SampleW-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface
`default_nettype wire

### rtl/rmt_out_if.sv
// Interface: result channel, valid/ready with median, count and overflow.
`default_nettype none
interface rmt_out_if #(
	parameter int SampleW = rmt_pkg::SAMPLE_WIDTH_DEF,
	parameter int CountW  = $clog2(rmt_pkg::CAPACITY_DEF + 1)
);
	logic                    valid;
	logic                    ready;
	logic signed [SampleW:0] median_doubled;
	logic [CountW-1:0]       sample_count;
	logic                    overflow;

	modport source (output valid, output median_doubled, output sample_count,
		output overflow, input ready);
	modport sink (input valid, input median_doubled, input sample_count,
		input overflow, output ready);
endinterface
`default_nettype wire

### rtl/rmt_cell.sv
// Chain cell: holds one sorted sample and takes it from itself, a neighbor or the input.
`default_nettype none
module rmt_cell #(
	parameter int SampleW = rmt_pkg::SAMPLE_WIDTH_DEF,
	parameter bit IsMid   = 1'b0
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire rmt_pkg::ctl_t             ctl,
	input  wire logic signed [SampleW-1:0] smp_val,
	input  wire logic signed [SampleW-1:0] lft_val,
	input  wire logic                      lft_occ,
	input  wire logic                      lft_gt,
	input  wire logic signed [SampleW-1:0] rgt_val,
	input  wire logic                      rgt_occ,
	input  wire logic                      rgt_gt,
	output logic signed [SampleW-1:0]      val,
	output logic                           occ,
	output logic                           gt
);

	logic signed [SampleW-1:0] val_q;
	logic                      occ_q;
	logic signed [SampleW-1:0] val_nxt;
	logic                      occ_nxt;

	assign val = val_q;
	assign occ = occ_q;
	assign gt  = occ_q && (val_q > smp_val);

	always_comb begin
		val_nxt = val_q;
		occ_nxt = occ_q;
		if (ctl.ins) begin
			if (ctl.seed) begin
				if (IsMid) begin
					val_nxt = smp_val;
					occ_nxt = 1'b1;
				end
			end else if (ctl.pull_rgt) begin
				occ_nxt = occ_q || rgt_occ;
				if (rgt_occ && !rgt_gt) begin
					val_nxt = rgt_val;
				end else if (!gt) begin
					val_nxt = smp_val;
				end
			end else begin
				occ_nxt = occ_q || lft_occ;
				if (!(occ_q && !gt)) begin
					val_nxt = lft_gt ? lft_val : smp_val;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			occ_q <= occ_nxt;
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_nxt;
	end

endmodule
`default_nettype wire

### rtl/running_median_tracker_top.sv
// Top level: running median tracker built on a centered chain of sorted cells.
//
//   channel | dir | payload                                        | handshake
//   smp     | in  | sample                                         | valid/ready
//   res     | out | median_doubled, sample_count, overflow         | valid/ready
//
// One item per cycle while no result stalls; the result shows the cycle after acceptance.
// Every cell updates in an accepting cycle unless the store is full; the sorted
// set stays centered so the median always sits in the two fixed middle cells.
// Reset clears the occupancy flags and the count; no clearing pass.
// A stalled result holds the chain: an item enters only if no result is held.
`default_nettype none
module running_median_tracker_top #(
	parameter int CAPACITY     = rmt_pkg::CAPACITY_DEF,
	parameter int SAMPLE_WIDTH = rmt_pkg::SAMPLE_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	rmt_in_if.sink   smp,
	rmt_out_if.source res
);

	localparam int CountW = $clog2(CAPACITY + 1);
	localparam int Mid    = (CAPACITY - 1) / 2;
	localparam logic [CountW-1:0] CapCnt = CountW'(CAPACITY);

	logic signed [SAMPLE_WIDTH-1:0] cell_val [CAPACITY];
	logic [CAPACITY-1:0]            cell_occ;
	logic [CAPACITY-1:0]            cell_gt;

	logic [CountW-1:0] cnt_q;
	logic              out_vld_q;
	logic              ovf_q;
	logic              accept;
	logic              full;
	rmt_pkg::ctl_t     ctl;

	assign full      = (cnt_q == CapCnt);
	assign accept    = smp.valid && smp.ready;
	assign smp.ready = !out_vld_q || res.ready;

	assign ctl.ins      = accept && !full;
	assign ctl.seed     = (cnt_q == '0);
	assign ctl.pull_rgt = !cnt_q[0] && (cnt_q != '0);

	for (genvar c = 0; c < CAPACITY; c++) begin : g_cell
		logic signed [SAMPLE_WIDTH-1:0] lft_val;
		logic                           lft_occ;
		logic                           lft_gt;
		logic signed [SAMPLE_WIDTH-1:0] rgt_val;
		logic                           rgt_occ;
		logic                           rgt_gt;

		if (c == 0) begin : g_lft_edge
			assign lft_val = '0;
			assign lft_occ = 1'b0;
			assign lft_gt  = 1'b0;
		end else begin : g_lft
			assign lft_val = cell_val[c-1];
			assign lft_occ = cell_occ[c-1];
			assign lft_gt  = cell_gt[c-1];
		end

		if (c == CAPACITY - 1) begin : g_rgt_edge
			assign rgt_val = '0;
			assign rgt_occ = 1'b0;
			assign rgt_gt  = 1'b0;
		end else begin : g_rgt
			assign rgt_val = cell_val[c+1];
			assign rgt_occ = cell_occ[c+1];
			assign rgt_gt  = cell_gt[c+1];
		end

		rmt_cell #(
			.SampleW (SAMPLE_WIDTH),
			.IsMid   (c == Mid)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.smp_val (smp.sample),
			.lft_val (lft_val),
			.lft_occ (lft_occ),
			.lft_gt  (lft_gt),
			.rgt_val (rgt_val),
			.rgt_occ (rgt_occ),
			.rgt_gt  (rgt_gt),
			.val     (cell_val[c]),
			.occ     (cell_occ[c]),
			.gt      (cell_gt[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (ctl.ins) begin
				cnt_q <= cnt_q + CountW'(1);
			end
			if (accept) begin
				out_vld_q <= 1'b1;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ovf_q <= full;
		end
	end

	assign res.valid          = out_vld_q;
	assign res.sample_count   = cnt_q;
	assign res.overflow       = ovf_q;
	assign res.median_doubled = cnt_q[0]
		? {cell_val[Mid], 1'b0}
		: ({cell_val[Mid][SAMPLE_WIDTH-1], cell_val[Mid]}
			+ {cell_val[Mid+1][SAMPLE_WIDTH-1], cell_val[Mid+1]});

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CapCnt)
		else $error("count above capacity");

	a_occ_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_occ) == 32'(cnt_q))
		else $error("occupied cells differ from count");

	a_mid_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) |-> (cell_occ[Mid] && (cnt_q[0] || cell_occ[Mid+1])))
		else $error("middle cells not occupied");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !full) |=> (cnt_q == $past(cnt_q) + CountW'(1)))
		else $error("count did not advance on insert");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.overflow) |-> full)
		else $error("overflow without full store");

endmodule
`default_nettype wire
